@@ hw/rtl/bbm_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants for the bed matching block.
package bbm_pkg;
  localparam int unsigned IdxW = 6;
  localparam int unsigned RowW = 64;
endpackage

@@ hw/rtl/bipartite_bed_matching.sv @@
`timescale 1ns / 1ps
// Bed matching: loads node rows, then runs augmenting-path matching from a stack.
// Load beat: one cycle each, busy stays low unless a solve runs.
// A last beat starts a solve; busy stays high until the solve ends, each search step
// reading a node row (S_RD) and then scanning it (S_SCAN).
// out_valid pulses one cycle at the end of the solve; the receiver cannot stall.
// Reset clears flags, node count and control; the row and owner memories need no clear.
module bipartite_bed_matching #(
  parameter int unsigned MAX_NODES = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [bbm_pkg::IdxW-1:0] in_node_index,
  input  logic                     in_in_school,
  input  logic                     in_goes_home,
  input  logic [bbm_pkg::RowW-1:0] in_neighbor_row,
  input  logic                     in_last,
  output logic                     out_valid,
  output logic                     out_all_placed
);
  localparam int unsigned N  = bbm_pkg::RowW;
  localparam int unsigned IW = bbm_pkg::IdxW;
  localparam logic [2:0] S_IDLE = 3'd0, S_NEXT = 3'd1, S_RD = 3'd2, S_SCAN = 3'd3,
                         S_POP = 3'd4, S_PUSH = 3'd5, S_COMMIT = 3'd6, S_DONE = 3'd7;

  logic [N-1:0] adj_mem [N];
  logic [IW-1:0] owner_mem [N];
  logic [2*IW-1:0] stk_mem [N];
  logic [N-1:0] adj_q;
  logic [IW-1:0] owner_q;
  logic [2*IW-1:0] stk_q;

  logic [2:0] st_r;
  logic [N-1:0] school_r, home_r, used_r, lm_r, vis_r;
  logic [IW:0] cnt_r;
  logic [IW-1:0] cur_r, u_r, top_r, v_r;
  logic [IW:0] scan_r;
  logic res_r, ov_r;

  logic acc;
  assign acc = start && !busy && ({1'b0, in_node_index} < (IW+1)'(MAX_NODES));
  assign busy = (st_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_all_placed = res_r;

  // adjacency read address: the node whose row is scanned
  logic [IW-1:0] adj_ra;
  always_ff @(posedge clk) begin
    if (acc) adj_mem[in_node_index] <= in_neighbor_row;
    adj_q <= adj_mem[adj_ra];
  end

  // candidate bed search over the row
  logic [N-1:0] cand, lowmask, avail;
  logic found;
  logic [IW-1:0] fv;
  always_comb begin
    lowmask = '0;
    for (int i = 0; i < N; i++) lowmask[i] = (IW+1)'(i) >= scan_r && (IW+1)'(i) < cnt_r;
    cand = adj_q;
    cand[u_r] = 1'b1;
    avail = cand & school_r & ~vis_r & lowmask;
    found = |avail;
    fv = '0;
    for (int i = N-1; i >= 0; i--) if (avail[i]) fv = IW'(i);
  end

  logic stk_we;
  logic [IW-1:0] stk_wa, stk_ra;
  logic [2*IW-1:0] stk_wd;
  logic own_we;
  logic [IW-1:0] own_wa, own_wd;
  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    stk_q <= stk_mem[stk_ra];
    if (own_we) owner_mem[own_wa] <= own_wd;
    // owner of the bed picked in the scan, used by the push
    owner_q <= owner_mem[fv];
  end

  logic needs;
  assign needs = (!school_r[cur_r] || !home_r[cur_r]) && !lm_r[cur_r];

  always_comb begin
    adj_ra = u_r;
    stk_we = 1'b0; stk_wa = top_r; stk_wd = {u_r, fv};
    stk_ra = top_r;
    own_we = 1'b0; own_wa = v_r; own_wd = u_r;
    if (st_r == S_SCAN) begin
      stk_we = found;
      // fetch the parent frame for a pop or a commit
      stk_ra = top_r - 1'b1;
    end
    if (st_r == S_COMMIT) begin
      own_we = 1'b1;
      stk_ra = top_r - IW'(2);
    end
    if (st_r == S_PUSH) begin
      stk_we = 1'b1; stk_wa = top_r + 1'b1; stk_wd = {owner_q, {IW{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; school_r <= '0; home_r <= '0; cnt_r <= '0;
      ov_r <= 1'b0; res_r <= 1'b0; used_r <= '0; lm_r <= '0; vis_r <= '0;
      cur_r <= '0; u_r <= '0; top_r <= '0; v_r <= '0; scan_r <= '0;
    end else begin
      ov_r <= 1'b0;
      case (st_r)
        S_IDLE: if (acc) begin
          school_r[in_node_index] <= in_in_school;
          home_r[in_node_index] <= in_goes_home;
          if (in_last) begin
            cnt_r <= {1'b0, in_node_index} + 1'b1;
            used_r <= '0; lm_r <= '0; cur_r <= '0;
            st_r <= S_NEXT;
          end
        end
        S_NEXT: begin
          if ({1'b0, cur_r} >= cnt_r) begin
            res_r <= 1'b1; st_r <= S_DONE;
          end else if (needs) begin
            vis_r <= '0; u_r <= cur_r; top_r <= '0; scan_r <= '0;
            st_r <= S_RD;
          end else if (cur_r == IW'(N-1)) begin
            res_r <= 1'b1; st_r <= S_DONE;
          end else cur_r <= cur_r + 1'b1;
        end
        S_RD: st_r <= S_SCAN;
        S_SCAN: begin
          if (!found) begin
            if (top_r == '0) begin
              res_r <= 1'b0; st_r <= S_DONE;
            end else st_r <= S_POP;
          end else begin
            vis_r[fv] <= 1'b1; v_r <= fv;
            if (!used_r[fv]) st_r <= S_COMMIT;
            else if ({1'b0, top_r} + 1'b1 >= (IW+1)'(MAX_NODES)) begin
              res_r <= 1'b0; st_r <= S_DONE;
            end else st_r <= S_PUSH;
          end
        end
        S_POP: begin
          // parent frame arrived from the read issued in the scan
          top_r <= top_r - 1'b1;
          u_r <= stk_q[2*IW-1:IW];
          scan_r <= {1'b0, stk_q[IW-1:0]} + 1'b1;
          st_r <= S_RD;
        end
        S_PUSH: begin
          top_r <= top_r + 1'b1; u_r <= owner_q; scan_r <= '0; st_r <= S_RD;
        end
        S_COMMIT: begin
          // u_r/v_r hold the frame being committed; stk_q holds the one below
          used_r[v_r] <= 1'b1;
          lm_r[u_r] <= 1'b1;
          if (top_r == '0) begin
            if (cur_r == IW'(N-1) || {1'b0, cur_r} + 1'b1 >= cnt_r) begin
              res_r <= 1'b1; st_r <= S_DONE;
            end else begin
              cur_r <= cur_r + 1'b1; st_r <= S_NEXT;
            end
          end else begin
            top_r <= top_r - 1'b1;
            u_r <= stk_q[2*IW-1:IW];
            v_r <= stk_q[IW-1:0];
          end
        end
        S_DONE: begin
          ov_r <= 1'b1; st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
